// File: src/vl2n_pkg.sv
// ----------------------------------------------------------------------------
// vl2n_pkg
// Shared types and constants of the vector L2 norm block: output field
// widths, status codes and the status bundle of the square-root unit.
// ----------------------------------------------------------------------------
package vl2n_pkg;

    // fixed widths of the item fields
    localparam int LANES_FIELD_W = 3;
    localparam int SUM_W         = 48;
    localparam int NORM_W        = 24;
    localparam int OUT_TDATA_W   = SUM_W + NORM_W;

    // result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_OVERFLOW = 1'b1;

    // status of the square-root unit as seen by the accumulator
    typedef struct packed {
        logic busy;   // iterating on a sum
        logic full;   // result register holds an untaken result
    } sqrt_status_t;

endpackage

// File: src/vl2n_lane.sv
// ----------------------------------------------------------------------------
// vl2n_lane
// One lane: absolute value of a signed element and its registered square.
// A lane beyond the valid count contributes zero.
// ----------------------------------------------------------------------------
module vl2n_lane
    import vl2n_pkg::*;
#(
    parameter int ELEM_WIDTH = 16
)
(
    input  logic                        clk,
    input  logic                        en,
    input  logic                        lane_used,
    input  logic signed [ELEM_WIDTH-1:0] elem,
    output logic [2*ELEM_WIDTH-1:0]     square
);

    logic [ELEM_WIDTH-1:0]   mag;
    logic [2*ELEM_WIDTH-1:0] mag_ext;
    logic [2*ELEM_WIDTH-1:0] square_reg;
    logic [2*ELEM_WIDTH-1:0] square_next;

    // magnitude; the most negative value maps to 2^(ELEM_WIDTH-1)
    always_comb
    begin
        if (elem[ELEM_WIDTH-1])
        begin
            mag = ~elem + 1'b1;
        end
        else
        begin
            mag = elem;
        end
        mag_ext     = {{ELEM_WIDTH{1'b0}}, mag};
        square_next = lane_used ? (mag_ext * mag_ext) : '0;
    end

    // square register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            square_reg <= square_next;
        end
    end

    assign square = square_reg;

endmodule

// File: src/vl2n_merge.sv
// ----------------------------------------------------------------------------
// vl2n_merge
// Adds the lane squares of one item, then folds the item sum into the
// saturating running sum. On a last item it hands the final sum and the
// overflow flag to the square-root unit and clears the running state.
// ----------------------------------------------------------------------------
module vl2n_merge
    import vl2n_pkg::*;
#(
    parameter int LANES      = 4,
    parameter int ELEM_WIDTH = 16,
    parameter int ACC_WIDTH  = 48
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_last,
    input  logic [LANES-1:0][2*ELEM_WIDTH-1:0]  squares,
    input  sqrt_status_t                        sqrt_stat,
    output logic                                advance,
    output logic                                sqrt_start,
    output logic [ACC_WIDTH-1:0]                final_sum,
    output logic                                final_ovf
);

    localparam int ITEM_W = 2*ELEM_WIDTH + $clog2(LANES);
    localparam int ADD_W  = ((ACC_WIDTH > ITEM_W) ? ACC_WIDTH : ITEM_W) + 1;
    localparam logic [ADD_W-1:0] ACC_MAX = ADD_W'({ACC_WIDTH{1'b1}});

    logic                 item_valid_reg;
    logic                 item_last_reg;
    logic [ITEM_W-1:0]    item_sum_reg;
    logic [ITEM_W-1:0]    tree_sum;
    logic [ACC_WIDTH-1:0] acc_reg;
    logic [ACC_WIDTH-1:0] acc_next;
    logic                 ovf_reg;
    logic                 ovf_next;
    logic [ADD_W-1:0]     total;
    logic                 take;

    // sum of the lane squares
    always_comb
    begin
        tree_sum = '0;
        for (int i = 0; i < LANES; i++)
        begin
            tree_sum = tree_sum + ITEM_W'(squares[i]);
        end
    end

    // a last item waits until the square-root unit is free
    assign take    = item_valid_reg && (!item_last_reg || (!sqrt_stat.busy && !sqrt_stat.full));
    assign advance = !item_valid_reg || take;

    // saturating accumulate; overflow is sticky until the vector ends
    always_comb
    begin
        total    = ADD_W'(acc_reg) + ADD_W'(item_sum_reg);
        ovf_next = ovf_reg || (total > ACC_MAX);
        acc_next = ovf_next ? {ACC_WIDTH{1'b1}} : total[ACC_WIDTH-1:0];
    end

    assign sqrt_start = take && item_last_reg;
    assign final_sum  = acc_next;
    assign final_ovf  = ovf_next;

    // item sum stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            item_last_reg  <= 1'b0;
        end
        else if (advance)
        begin
            item_valid_reg <= in_valid;
            item_last_reg  <= in_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_sum_reg <= tree_sum;
        end
    end

    // running sum and sticky overflow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (take)
        begin
            if (item_last_reg)
            begin
                acc_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                acc_reg <= acc_next;
                ovf_reg <= ovf_next;
            end
        end
    end

endmodule

// File: src/vl2n_sqrt.sv
// ----------------------------------------------------------------------------
// vl2n_sqrt
// Iterative floor square root, one result bit per cycle, followed by the
// output register that holds a finished result until it is taken.
// ----------------------------------------------------------------------------
module vl2n_sqrt
    import vl2n_pkg::*;
#(
    parameter int ACC_WIDTH = 48
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [ACC_WIDTH-1:0] value,
    input  logic                 ovf,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [SUM_W-1:0]     out_sum,
    output logic [NORM_W-1:0]    out_norm,
    output logic                 out_status,
    output sqrt_status_t         stat
);

    localparam int STEPS = (ACC_WIDTH + 1) / 2;
    localparam int W     = ACC_WIDTH + 1;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [W-1:0] BIT_INIT = W'(1) << (2*(STEPS-1));

    logic               busy_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [W-1:0]       rem_reg;
    logic [W-1:0]       rem_next;
    logic [W-1:0]       res_reg;
    logic [W-1:0]       res_next;
    logic [W-1:0]       bit_reg;
    logic [W-1:0]       trial;
    logic [SUM_W-1:0]   sum_hold_reg;
    logic               ovf_hold_reg;
    logic               out_valid_reg;
    logic [SUM_W-1:0]   out_sum_reg;
    logic [NORM_W-1:0]  out_norm_reg;
    logic               out_status_reg;
    logic               finish;

    // one restoring step
    always_comb
    begin
        trial = res_reg + bit_reg;
        if (rem_reg >= trial)
        begin
            rem_next = rem_reg - trial;
            res_next = (res_reg >> 1) + bit_reg;
        end
        else
        begin
            rem_next = rem_reg;
            res_next = res_reg >> 1;
        end
    end

    assign finish = busy_reg && (cnt_reg == '0);

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(STEPS - 1);
        end
        else if (busy_reg)
        begin
            busy_reg <= !finish;
            cnt_reg  <= cnt_reg - 1'b1;
        end
    end

    // datapath of the root
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg      <= W'(value);
            res_reg      <= '0;
            bit_reg      <= BIT_INIT;
            sum_hold_reg <= SUM_W'(value);
            ovf_hold_reg <= ovf;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            res_reg <= res_next;
            bit_reg <= bit_reg >> 2;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_sum_reg    <= sum_hold_reg;
            out_norm_reg   <= ovf_hold_reg ? '0 : NORM_W'(res_next);
            out_status_reg <= ovf_hold_reg ? STATUS_OVERFLOW : STATUS_OK;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sum    = out_sum_reg;
    assign out_norm   = out_norm_reg;
    assign out_status = out_status_reg;
    assign stat.busy  = busy_reg;
    assign stat.full  = out_valid_reg;

endmodule

// File: src/vector_l2_norm.sv
// ----------------------------------------------------------------------------
// vector_l2_norm
// Streaming sum of squares and Euclidean norm of fixed-point vectors.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries a vector as a run of items, each with LANES signed Q8.8
//   elements and a count of leading valid lanes; tlast marks the final item.
//   m_axis gives one result per vector: the Q32.16 sum of squares, its floor
//   square root (Q16.8 norm) and a status flag in tuser (1 = overflow; the sum
//   is then saturated and the norm is 0).
//   Throughput: items that are not last are taken one per cycle while no last
//   item waits in the item sum stage; the lane multipliers and the adder are
//   fully pipelined. A last item occupies the iterative square-root unit, and
//   the next last item waits in the item sum stage until that unit is idle and
//   its result register is empty. After the last item transfer, the result
//   passes the square register, the item sum stage, the root iterations and
//   the output register before m_axis_tvalid rises.
//   When the receiver stalls, the result waits in the output register while
//   further items of the next vector are still taken.
//   Reset clears the running sum, the overflow flag and all valid flags.
// ----------------------------------------------------------------------------
module vector_l2_norm
    import vl2n_pkg::*;
#(
    parameter int LANES      = 4,
    parameter int ELEM_WIDTH = 16,
    parameter int ACC_WIDTH  = 48
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // element_0 .. element_(LANES-1), lanes_valid, zero fill
    input  logic [((LANES*ELEM_WIDTH+LANES_FIELD_W+7)/8)*8-1:0] s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // sum_of_squares, norm_value
    output logic [OUT_TDATA_W-1:0]              m_axis_tdata,
    // status
    output logic                                m_axis_tuser
);

    logic [LANES_FIELD_W-1:0]           lanes_valid;
    logic [LANES-1:0][2*ELEM_WIDTH-1:0] squares;
    logic                               advance;
    logic                               sq_valid_reg;
    logic                               sq_last_reg;
    logic                               sqrt_start;
    logic [ACC_WIDTH-1:0]               final_sum;
    logic                               final_ovf;
    sqrt_status_t                       sqrt_stat;
    logic [SUM_W-1:0]                   out_sum;
    logic [NORM_W-1:0]                  out_norm;

    assign lanes_valid   = s_axis_tdata[LANES*ELEM_WIDTH +: LANES_FIELD_W];
    assign s_axis_tready = advance;

    // lane squares
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        vl2n_lane #(
            .ELEM_WIDTH (ELEM_WIDTH)
        ) u_lane (
            .clk       (clk),
            .en        (advance),
            .lane_used (32'(lanes_valid) > i),
            .elem      (s_axis_tdata[i*ELEM_WIDTH +: ELEM_WIDTH]),
            .square    (squares[i])
        );
    end

    // valid and last of the square stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
            sq_last_reg  <= 1'b0;
        end
        else if (advance)
        begin
            sq_valid_reg <= s_axis_tvalid;
            sq_last_reg  <= s_axis_tlast;
        end
    end

    // item sum and running sum
    vl2n_merge #(
        .LANES      (LANES),
        .ELEM_WIDTH (ELEM_WIDTH),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sq_valid_reg),
        .in_last    (sq_last_reg),
        .squares    (squares),
        .sqrt_stat  (sqrt_stat),
        .advance    (advance),
        .sqrt_start (sqrt_start),
        .final_sum  (final_sum),
        .final_ovf  (final_ovf)
    );

    // square root and output register
    vl2n_sqrt #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (sqrt_start),
        .value      (final_sum),
        .ovf        (final_ovf),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_sum    (out_sum),
        .out_norm   (out_norm),
        .out_status (m_axis_tuser),
        .stat       (sqrt_stat)
    );

    assign m_axis_tdata = {out_norm, out_sum};

    // checks
    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start |-> (!sqrt_stat.busy && !sqrt_stat.full))
        else $error("root started while busy or holding a result");

    a_stall_only_on_root: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (sqrt_stat.busy || sqrt_stat.full))
        else $error("input stalled with the root unit free");

    a_overflow_norm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == STATUS_OVERFLOW) |-> (out_norm == '0))
        else $error("overflow result carries a nonzero norm");

    a_start_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start |=> sqrt_stat.busy)
        else $error("root unit did not start");

endmodule
